// ===== hdl/bacps_pkg.sv =====
// shared types and constants for the bar-aligned punch-in scheduler
// no dependencies; used by the controller, the datapath and the top level
package bacps_pkg;

  // request codes carried in the input tuser
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // result kinds carried in the output tuser
  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_MSG = 1'b1;

  // width of the slot number in a result
  localparam int SLOT_OUT_W = 3;

  // input and output tdata widths
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 24;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the accepted input transaction
    logic clear;    // free every slot
    logic ack;      // allocate a slot and load the acknowledgement
    logic step;     // process the slot under the scan index
    logic flush;    // move the pending message out as the final result
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
    logic pend_valid;  // a message is held back awaiting its last flag
    logic slot_emit;   // the scanned slot produces a message
  } status_t;

  // one result item
  typedef struct packed {
    logic                  kind;
    logic                  accepted;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [3:0]            channel;
    logic [6:0]            cc_number;
    logic [6:0]            cc_value;
    logic                  last;
  } result_t;

endpackage

// ===== hdl/bar_aligned_cc_punch_scheduler.sv =====
// start request: accepted in ST_IDLE, then the acknowledgement is loaded into the output register from ST_ACK
// beat tick: slots are scanned in turn through the shared slot evaluator, with no new input taken until the scan ends
// clear and unused codes: handled in ST_IDLE; the output register lets the next item in while a result waits
// a stalled output can hold ST_ACK, ST_SCAN and ST_FLUSH while waiting for m_axis_tready
// synchronous active-high reset frees all slots, clears the channel to 0 and empties the outputs
// top level: instantiates bacps_ctrl and bacps_datapath, depends on bacps_pkg
module bar_aligned_cc_punch_scheduler #(
  parameter int SLOT_COUNT = 2
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: midi_channel
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // on_cc[6:0], on_val[13:7], off_cc[20:14], off_val[27:21],
  // beats[35:28], beat[43:36], programming_mode[44], zero[47:45]
  input  logic [47:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // accepted[0], slot_index[3:1], channel[7:4], cc_number[14:8], cc_value[21:15], zero[23:22]
  output logic [23:0] m_axis_tdata,
  // kind[0]
  output logic [0:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  bacps_pkg::cmd_t    cmd;
  bacps_pkg::status_t status;
  bacps_pkg::result_t res;
  logic [IDX_W-1:0]   idx;

  // controller
  bacps_ctrl #(
    .SLOT_COUNT(SLOT_COUNT),
    .IDX_W(IDX_W)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(s_axis_tvalid),
    .req_type(s_axis_tuser),
    .status(status),
    .in_ready(s_axis_tready),
    .cmd(cmd),
    .idx(idx)
  );

  // datapath
  bacps_datapath #(
    .SLOT_COUNT(SLOT_COUNT),
    .IDX_W(IDX_W)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_data(s_axis_tdata),
    .cmd(cmd),
    .idx(idx),
    .out_ready(m_axis_tready),
    .status(status),
    .out_valid(m_axis_tvalid),
    .out_res(res)
  );

  // result packing
  assign m_axis_tdata = {2'b00, res.cc_value, res.cc_number, res.channel,
                         res.slot_index, res.accepted};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

  // an acknowledgement is always the only result of its transaction
  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0] == bacps_pkg::KIND_ACK) |-> m_axis_tlast)
    else $error("start acknowledgement without last");

  // control change messages never carry the accepted flag
  a_msg_not_accepted: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0] == bacps_pkg::KIND_MSG) |-> !m_axis_tdata[0])
    else $error("message result with accepted set");

  // a tick occupies the block while its slots are scanned
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == bacps_pkg::REQ_TICK)
    |=> !s_axis_tready)
    else $error("input taken during slot scan");

  // a flush only happens with a pending message and room in the output register
  a_flush_pending: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |-> (status.pend_valid && status.out_free))
    else $error("flush without a pending message or output space");

endmodule

// ===== hdl/bacps_ctrl.sv =====
// controller state machine of the punch-in scheduler: sequences start, tick and clear
// depends on bacps_pkg (cmd_t, status_t, request codes)
module bacps_ctrl #(
  parameter int SLOT_COUNT = 2,
  parameter int IDX_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [1:0]            req_type,
  input  bacps_pkg::status_t    status,
  output logic                  in_ready,
  output bacps_pkg::cmd_t       cmd,
  output logic [IDX_W-1:0]      idx
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ACK   = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [IDX_W-1:0] idx_next;
  logic             stall;

  // a new message cannot be held while both the pending and output registers are full
  assign stall = status.slot_emit && status.pend_valid && !status.out_free;

  // next state and commands
  always_comb begin
    state_next  = state;
    idx_next    = idx;
    in_ready    = 1'b0;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (req_type)
            bacps_pkg::REQ_START: state_next = ST_ACK;
            bacps_pkg::REQ_TICK: begin
              idx_next   = '0;
              state_next = ST_SCAN;
            end
            bacps_pkg::REQ_CLEAR: cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_ACK: begin
        if (status.out_free) begin
          cmd.ack    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          cmd.step = 1'b1;
          if (idx == IDX_W'(SLOT_COUNT - 1)) begin
            state_next = ST_FLUSH;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (!status.pend_valid) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state and scan index registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

// ===== hdl/bacps_datapath.sv =====
// datapath of the punch-in scheduler: slot storage, slot evaluation, pending and output registers
// depends on bacps_pkg (cmd_t, status_t, result_t, codes)
module bacps_datapath #(
  parameter int SLOT_COUNT = 2,
  parameter int IDX_W = 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [3:0]                       cfg_wdata,
  input  logic [bacps_pkg::IN_DATA_W-1:0]  in_data,
  input  bacps_pkg::cmd_t                  cmd,
  input  logic [IDX_W-1:0]                 idx,
  input  logic                             out_ready,
  output bacps_pkg::status_t               status,
  output logic                             out_valid,
  output bacps_pkg::result_t               out_res
);

  localparam int SLOT_OUT_W = bacps_pkg::SLOT_OUT_W;

  // configuration and latched input
  logic [3:0]  midi_channel;
  logic [6:0]  in_on_cc, in_on_val, in_off_cc, in_off_val;
  logic [7:0]  in_duration;
  logic        beat_one;
  logic        quiet;

  // slot storage
  logic [SLOT_COUNT-1:0] slot_active;
  logic [SLOT_COUNT-1:0] slot_recording;
  logic [6:0] slot_on_cc      [SLOT_COUNT];
  logic [6:0] slot_on_val     [SLOT_COUNT];
  logic [6:0] slot_off_cc     [SLOT_COUNT];
  logic [6:0] slot_off_val    [SLOT_COUNT];
  logic [7:0] slot_beats_left [SLOT_COUNT];

  // pending message
  logic               pend_valid;
  bacps_pkg::result_t pend_res;

  logic             out_free;
  logic             out_load_en;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             cur_act, cur_rec, msg_start, msg_finish, emit;
  logic [7:0]       cur_beats, beats_dec;
  bacps_pkg::result_t new_msg;
  bacps_pkg::result_t out_load;

  assign out_free = !out_valid || out_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      midi_channel <= '0;
    end else if (cfg_we) begin
      midi_channel <= cfg_wdata;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_on_cc    <= in_data[6:0];
      in_on_val   <= in_data[13:7];
      in_off_cc   <= in_data[20:14];
      in_off_val  <= in_data[27:21];
      in_duration <= in_data[35:28];
      beat_one    <= (in_data[43:36] == 8'd1);
      quiet       <= in_data[44];
    end
  end

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_active[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // evaluation of the slot under the scan index
  always_comb begin
    cur_act    = slot_active[idx];
    cur_rec    = slot_recording[idx];
    cur_beats  = slot_beats_left[idx];
    beats_dec  = (cur_beats == 8'd0) ? 8'd0 : cur_beats - 8'd1;
    msg_start  = cur_act && !cur_rec && beat_one;
    msg_finish = cur_act && cur_rec && (beats_dec == 8'd0);
    emit       = (msg_start || msg_finish) && !quiet;
    new_msg            = '0;
    new_msg.kind       = bacps_pkg::KIND_MSG;
    new_msg.slot_index = SLOT_OUT_W'(idx);
    new_msg.channel    = midi_channel;
    new_msg.cc_number  = msg_start ? slot_on_cc[idx] : slot_off_cc[idx];
    new_msg.cc_value   = msg_start ? slot_on_val[idx] : slot_off_val[idx];
  end

  assign status.out_free   = out_free;
  assign status.pend_valid = pend_valid;
  assign status.slot_emit  = emit;

  // slot control bits
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active    <= '0;
      slot_recording <= '0;
    end else if (cmd.clear) begin
      slot_active <= '0;
    end else if (cmd.ack && free_found) begin
      slot_active[free_idx]    <= 1'b1;
      slot_recording[free_idx] <= 1'b0;
    end else if (cmd.step) begin
      if (msg_start) begin
        slot_recording[idx] <= 1'b1;
      end
      if (msg_finish) begin
        slot_active[idx] <= 1'b0;
      end
    end
  end

  // slot payload, written on allocation and on countdown
  always_ff @(posedge clk) begin
    if (cmd.ack && free_found) begin
      slot_on_cc[free_idx]      <= in_on_cc;
      slot_on_val[free_idx]     <= in_on_val;
      slot_off_cc[free_idx]     <= in_off_cc;
      slot_off_val[free_idx]    <= in_off_val;
      slot_beats_left[free_idx] <= in_duration;
    end else if (cmd.step && cur_act && cur_rec) begin
      slot_beats_left[idx] <= beats_dec;
    end
  end

  // pending message: held until the next one or the end of the scan sets its last flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.step && emit) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && emit) begin
      pend_res <= new_msg;
    end
  end

  // value for the output register: acknowledgement or the pending message
  assign out_load_en = cmd.ack || cmd.flush || (cmd.step && emit && pend_valid);

  always_comb begin
    out_load      = pend_res;
    out_load.last = cmd.flush;
    if (cmd.ack) begin
      out_load            = '0;
      out_load.kind       = bacps_pkg::KIND_ACK;
      out_load.accepted   = free_found;
      out_load.slot_index = free_found ? SLOT_OUT_W'(free_idx) : '0;
      out_load.last       = 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_en) begin
      out_res <= out_load;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the bar-aligned punch-in scheduler
// drives start, tick and clear requests with random gaps and stalls
// against a local slot-table predictor; depends on bacps_pkg and the top level
module tb_top;

  localparam int SLOT_COUNT = 2;
  localparam int MAX_WAIT = 11;
  // longest internal pass (slot scan plus output register) with margin
  localparam int SETTLE_CYCLES = SLOT_COUNT + 6;
  localparam int LIMIT_TIME = 5000000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // one input transaction, unpacked into its fields
  typedef struct packed {
    logic [1:0] req;
    logic [6:0] on_cc;
    logic [6:0] on_val;
    logic [6:0] off_cc;
    logic [6:0] off_val;
    logic [7:0] beats;
    logic [7:0] beat;
    logic       quiet;
  } punch_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = 4'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = bacps_pkg::REQ_CLEAR;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // predictor copy of the slot table and the channel register
  logic       armed [SLOT_COUNT];
  logic       rolling [SLOT_COUNT];
  logic [6:0] slot_on_cc [SLOT_COUNT];
  logic [6:0] slot_on_val [SLOT_COUNT];
  logic [6:0] slot_off_cc [SLOT_COUNT];
  logic [6:0] slot_off_val [SLOT_COUNT];
  logic [7:0] slot_beats [SLOT_COUNT];
  logic [3:0] channel_now = 4'd0;

  bacps_pkg::result_t expected_results [$];
  int      errors = 0;
  logic    calm = 1'b0;

  bar_aligned_cc_punch_scheduler #(
    .SLOT_COUNT(SLOT_COUNT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // control change result as the scheduler should emit it
  function automatic bacps_pkg::result_t cc_message(int slot, logic [6:0] num,
                                                    logic [6:0] val);
    bacps_pkg::result_t res;
    res.kind = bacps_pkg::KIND_MSG;
    res.accepted = 1'b0;
    res.slot_index = slot[bacps_pkg::SLOT_OUT_W-1:0];
    res.channel = channel_now;
    res.cc_number = num;
    res.cc_value = val;
    res.last = 1'b0;
    return res;
  endfunction

  // slot table update and expected results for one accepted request
  function automatic void predict_request(punch_req_t r);
    int      free_slot;
    int      n;
    bacps_pkg::result_t res;
    free_slot = -1;
    n = 0;
    res = '0;
    case (r.req)
      bacps_pkg::REQ_START: begin
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
          if (!armed[i]) free_slot = i;
        res.kind = bacps_pkg::KIND_ACK;
        res.last = 1'b1;
        if (free_slot >= 0) begin
          armed[free_slot] = 1'b1;
          rolling[free_slot] = 1'b0;
          slot_on_cc[free_slot] = r.on_cc;
          slot_on_val[free_slot] = r.on_val;
          slot_off_cc[free_slot] = r.off_cc;
          slot_off_val[free_slot] = r.off_val;
          slot_beats[free_slot] = r.beats;
          res.accepted = 1'b1;
          res.slot_index = free_slot[bacps_pkg::SLOT_OUT_W-1:0];
        end
        expected_results.push_back(res);
      end
      bacps_pkg::REQ_TICK: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!armed[i]) continue;
          if (!rolling[i]) begin
            // waiting slots only wake on the bar start
            if (r.beat == 8'd1) begin
              if (!r.quiet) begin
                expected_results.push_back(cc_message(i, slot_on_cc[i], slot_on_val[i]));
                n++;
              end
              rolling[i] = 1'b1;
            end
          end else begin
            // countdown saturates at zero
            if (slot_beats[i] != 8'd0) slot_beats[i] = slot_beats[i] - 8'd1;
            if (slot_beats[i] == 8'd0) begin
              if (!r.quiet) begin
                expected_results.push_back(cc_message(i, slot_off_cc[i], slot_off_val[i]));
                n++;
              end
              armed[i] = 1'b0;
            end
          end
        end
        if (n > 0) begin
          res = expected_results[expected_results.size()-1];
          res.last = 1'b1;
          expected_results[expected_results.size()-1] = res;
        end
      end
      bacps_pkg::REQ_CLEAR: begin
        for (int i = 0; i < SLOT_COUNT; i++) armed[i] = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // request builders; fields the request does not use carry random content
  function automatic punch_req_t noise_req();
    punch_req_t r;
    r.req = 2'($urandom_range(0, 3));
    r.on_cc = 7'($urandom_range(0, 127));
    r.on_val = 7'($urandom_range(0, 127));
    r.off_cc = 7'($urandom_range(0, 127));
    r.off_val = 7'($urandom_range(0, 127));
    r.beats = 8'($urandom_range(0, 255));
    r.beat = 8'($urandom_range(0, 255));
    r.quiet = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic punch_req_t start_req(int on_cc, int on_val, int off_cc, int off_val,
                                           int beats);
    punch_req_t r;
    r = noise_req();
    r.req = bacps_pkg::REQ_START;
    r.on_cc = on_cc[6:0];
    r.on_val = on_val[6:0];
    r.off_cc = off_cc[6:0];
    r.off_val = off_val[6:0];
    r.beats = beats[7:0];
    return r;
  endfunction

  function automatic punch_req_t tick_req(int beat, logic quiet);
    punch_req_t r;
    r = noise_req();
    r.req = bacps_pkg::REQ_TICK;
    r.beat = beat[7:0];
    r.quiet = quiet;
    return r;
  endfunction

  function automatic punch_req_t other_req(logic [1:0] code);
    punch_req_t r;
    r = noise_req();
    r.req = code;
    return r;
  endfunction

  function automatic int idle_cycles();
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // one input transaction: optional gap, then hold until accepted
  task automatic send(punch_req_t r);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= r.req;
    s_axis_tdata <= {3'b000, r.quiet, r.beat, r.beats, r.off_val, r.off_cc, r.on_val, r.on_cc};
    do @(posedge clk); while (!s_axis_tready);
    predict_request(r);
  endtask

  // stop sending and let every expected result and internal pass finish
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // channel register write while the block is idle
  task automatic set_channel(logic [3:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    channel_now = value;
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // output side: random stall before each transaction
  initial begin
    int stall;
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // compare each accepted result with the oldest expectation
  task automatic check_result();
    bacps_pkg::result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: tdata %h tuser %h tlast %b",
                                m_axis_tdata, m_axis_tuser, m_axis_tlast));
      return;
    end
    want = expected_results.pop_front();
    if (m_axis_tuser[0] !== want.kind)
      report_mismatch($sformatf("kind %b, want %b", m_axis_tuser[0], want.kind));
    if (m_axis_tdata[0] !== want.accepted)
      report_mismatch($sformatf("accepted %b, want %b", m_axis_tdata[0], want.accepted));
    if (m_axis_tdata[3:1] !== want.slot_index)
      report_mismatch($sformatf("slot %0d, want %0d", m_axis_tdata[3:1], want.slot_index));
    if (m_axis_tdata[7:4] !== want.channel)
      report_mismatch($sformatf("channel %0d, want %0d", m_axis_tdata[7:4], want.channel));
    if (m_axis_tdata[14:8] !== want.cc_number)
      report_mismatch($sformatf("cc number %0d, want %0d", m_axis_tdata[14:8], want.cc_number));
    if (m_axis_tdata[21:15] !== want.cc_value)
      report_mismatch($sformatf("cc value %0d, want %0d", m_axis_tdata[21:15], want.cc_value));
    if (m_axis_tlast !== want.last)
      report_mismatch($sformatf("tlast %b, want %b", m_axis_tlast, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_result();
  end

  // allocation, rejection, bar start, countdown, zero duration, unused code and clear
  task automatic test_slot_allocation();
    send(start_req(127, 0, 0, 127, 0));
    send(start_req(0, 127, 127, 0, 255));
    send(start_req(85, 42, 42, 85, 3));
    send(tick_req(0, 1'b0));
    send(tick_req(255, 1'b0));
    send(tick_req(1, 1'b0));
    send(tick_req(1, 1'b0));
    send(start_req(1, 2, 3, 4, 1));
    send(tick_req(3, 1'b0));
    send(other_req(REQ_UNUSED));
    send(other_req(bacps_pkg::REQ_CLEAR));
    send(start_req(10, 20, 30, 40, 2));
    send(tick_req(1, 1'b0));
    drain();
  endtask

  // quiet ticks still advance the slots; two messages from one tick
  task automatic test_programming_mode();
    send(tick_req(1, 1'b1));
    send(tick_req(7, 1'b1));
    send(start_req(100, 101, 102, 103, 0));
    send(start_req(55, 66, 77, 88, 1));
    send(tick_req(1, 1'b1));
    send(tick_req(1, 1'b0));
    send(start_req($urandom_range(0, 127), $urandom_range(0, 127),
                   $urandom_range(0, 127), $urandom_range(0, 127), 1));
    send(start_req($urandom_range(0, 127), $urandom_range(0, 127),
                   $urandom_range(0, 127), $urandom_range(0, 127), 2));
    send(tick_req(1, 1'b0));
    send(other_req(bacps_pkg::REQ_CLEAR));
    drain();
  endtask

  function automatic int rand_duration();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
  endfunction

  function automatic int rand_beat();
    case ($urandom_range(0, 3))
      0, 1: return 1;
      2: return $urandom_range(2, 4);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // mostly start-then-tick runs with random content, some noise and clears
  task automatic test_random_traffic(int n_items);
    int         sent;
    punch_req_t r;
    sent = 0;
    while (sent < n_items) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        repeat ($urandom_range(1, 3)) begin
          send(start_req($urandom_range(0, 127), $urandom_range(0, 127),
                         $urandom_range(0, 127), $urandom_range(0, 127), rand_duration()));
          sent++;
        end
        repeat ($urandom_range(1, 8)) begin
          send(tick_req(rand_beat(), $urandom_range(0, 5) == 0));
          sent++;
        end
        if ($urandom_range(0, 4) == 0) begin
          send(other_req(bacps_pkg::REQ_CLEAR));
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 3)) begin
          r = noise_req();
          send(r);
          sent++;
        end
      end
    end
    calm = 1'b0;
    drain();
  endtask

  // main sequence
  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      armed[i] = 1'b0;
      rolling[i] = 1'b0;
      slot_on_cc[i] = '0;
      slot_on_val[i] = '0;
      slot_off_cc[i] = '0;
      slot_off_val[i] = '0;
      slot_beats[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_slot_allocation();
    set_channel(4'd15);
    test_programming_mode();
    set_channel(4'($urandom_range(1, 14)));
    test_random_traffic(95);
    set_channel(4'd0);
    test_random_traffic(95);
    set_channel(4'd15);
    test_random_traffic(95);
    set_channel(4'($urandom_range(0, 15)));
    test_random_traffic(95);
    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_TIME);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
